FILE: design/lbvh_pkg.sv
package lbvh_pkg;

    // Fixed field widths of the streaming payload
    localparam int IDX_W     = 10;
    localparam int CODE_IN_W = 30;
    localparam int LC_W      = 11;
    localparam int CHILD_W   = 11;

    // Packed bus widths
    localparam int S_TDATA_W = 40;   // index + code
    localparam int M_TDATA_W = 56;   // range, split, children, padded to whole bytes
    localparam int M_TUSER_W = 2;    // leaf flags

    // Internal signed position width: covers probes past either end of the leaf row
    localparam int POS_W = LC_W + 3;
    // Prefix length: -1 .. 64
    localparam int PL_W  = 8;

    localparam int MAX_LEAVES_DEF = 1024;
    localparam int CODE_BITS_DEF  = 30;

    localparam logic [LC_W-1:0] LEAF_COUNT_RESET = LC_W'(2);

    localparam logic signed [PL_W-1:0] PL_NONE    = -1;
    localparam logic signed [PL_W-1:0] PL_EQ_BASE = 32;

    // Command codes carried in s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_BUILD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CI,
        ST_UP,
        ST_DN,
        ST_GROW,
        ST_BIN,
        ST_CF,
        ST_DNODE,
        ST_SPLIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               right_is_leaf;
        logic               left_is_leaf;
        logic [CHILD_W-1:0] right_child;
        logic [CHILD_W-1:0] left_child;
        logic [IDX_W-1:0]   split_pos;
        logic [IDX_W-1:0]   range_last;
        logic [IDX_W-1:0]   range_first;
    } node_t;

    // Leading-zero count over 32 bits, five halving steps
    function automatic logic [5:0] clz32(input logic [31:0] x);
        logic [31:0] v;
        logic [5:0]  n;
        v = x;
        n = 6'd0;
        if (v == 32'd0) begin
            return 6'd32;
        end
        if (v[31:16] == 16'd0) begin
            n = n + 6'd16;
            v = v << 16;
        end
        if (v[31:24] == 8'd0) begin
            n = n + 6'd8;
            v = v << 8;
        end
        if (v[31:28] == 4'd0) begin
            n = n + 6'd4;
            v = v << 4;
        end
        if (v[31:30] == 2'd0) begin
            n = n + 6'd2;
            v = v << 2;
        end
        if (v[31] == 1'b0) begin
            n = n + 6'd1;
        end
        return n;
    endfunction

endpackage

FILE: design/lbvh_ram.sv
module lbvh_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/lbvh_plen.sv
module lbvh_plen #(
    parameter int CODE_BITS = lbvh_pkg::CODE_BITS_DEF
) (
    input  logic [CODE_BITS-1:0]          code_a,
    input  logic [CODE_BITS-1:0]          code_b,
    input  logic [lbvh_pkg::POS_W-1:0]    pos_a,
    input  logic [lbvh_pkg::POS_W-1:0]    pos_b,
    input  logic                          out_of_range,
    output logic signed [lbvh_pkg::PL_W-1:0] plen
);
    import lbvh_pkg::*;

    logic [31:0] code_x;
    logic [31:0] pos_x;
    logic [5:0]  clz_code;
    logic [5:0]  clz_pos;

    assign code_x   = 32'(code_a ^ code_b);
    assign pos_x    = 32'(pos_a[LC_W-1:0] ^ pos_b[LC_W-1:0]);
    assign clz_code = clz32(code_x);
    assign clz_pos  = clz32(pos_x);

    // Equal codes fall back on the position bits to break the tie
    always_comb begin
        if (out_of_range) begin
            plen = PL_NONE;
        end else if (code_a == code_b) begin
            plen = PL_EQ_BASE + $signed({2'b00, clz_pos});
        end else begin
            plen = $signed({2'b00, clz_code});
        end
    end

endmodule

FILE: design/lbvh_seq.sv
module lbvh_seq #(
    parameter int MAX_LEAVES = lbvh_pkg::MAX_LEAVES_DEF,
    parameter int CODE_BITS  = lbvh_pkg::CODE_BITS_DEF,
    localparam int ADDR_W    = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lbvh_pkg::LC_W-1:0]   n_eff,
    input  logic                        start,
    input  logic [lbvh_pkg::IDX_W-1:0]  start_idx,
    input  logic [CODE_BITS-1:0]        rdata,
    output logic [ADDR_W-1:0]           raddr,
    output logic                        idle,
    output logic                        res_valid,
    input  logic                        res_take,
    output lbvh_pkg::node_t             res
);
    import lbvh_pkg::*;

    localparam logic signed [POS_W-1:0] ONE = 1;
    localparam logic signed [POS_W-1:0] TWO = 2;

    state_t state_reg, state_next;

    logic signed [POS_W-1:0] i_reg, i_next;
    logic signed [POS_W-1:0] probe_reg, probe_next;
    logic                    oob_reg, oob_next;
    logic [CODE_BITS-1:0]    ci_reg, ci_next;
    logic [CODE_BITS-1:0]    cf_reg, cf_next;
    logic signed [PL_W-1:0]  up_reg, up_next;
    logic signed [PL_W-1:0]  dmin_reg, dmin_next;
    logic signed [PL_W-1:0]  dnode_reg, dnode_next;
    logic                    dir_reg, dir_next;      // 1: range grows upwards
    logic signed [POS_W-1:0] lmax_reg, lmax_next;
    logic signed [POS_W-1:0] l_reg, l_next;
    logic signed [POS_W-1:0] t_reg, t_next;
    logic signed [POS_W-1:0] first_reg, first_next;
    logic signed [POS_W-1:0] last_reg, last_next;
    logic signed [POS_W-1:0] s_reg, s_next;
    logic signed [POS_W-1:0] step_reg, step_next;

    logic signed [POS_W-1:0] n_pos;
    logic signed [POS_W-1:0] base_pos;
    logic [CODE_BITS-1:0]    base_code;
    logic signed [PL_W-1:0]  plen;
    logic                    use_first;

    logic signed [POS_W-1:0] lmax_dbl;
    logic signed [POS_W-1:0] l_new;
    logic signed [POS_W-1:0] t_half;
    logic signed [POS_W-1:0] l_off;
    logic signed [POS_W-1:0] span;
    logic signed [POS_W-1:0] step_half;
    logic signed [POS_W-1:0] s_new;
    logic signed [POS_W-1:0] split;
    logic                    dir_up;

    assign n_pos = POS_W'(n_eff);

    // The shared prefix unit compares the code just read against the base code
    assign use_first = (state_reg == ST_DNODE) || (state_reg == ST_SPLIT);
    assign base_pos  = use_first ? first_reg : i_reg;
    assign base_code = use_first ? cf_reg : ci_reg;

    lbvh_plen #(
        .CODE_BITS(CODE_BITS)
    ) u_plen (
        .code_a      (base_code),
        .code_b      (rdata),
        .pos_a       (base_pos),
        .pos_b       (probe_reg),
        .out_of_range(oob_reg),
        .plen        (plen)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        i_reg     <= i_next;
        probe_reg <= probe_next;
        oob_reg   <= oob_next;
        ci_reg    <= ci_next;
        cf_reg    <= cf_next;
        up_reg    <= up_next;
        dmin_reg  <= dmin_next;
        dnode_reg <= dnode_next;
        dir_reg   <= dir_next;
        lmax_reg  <= lmax_next;
        l_reg     <= l_next;
        t_reg     <= t_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        s_reg     <= s_next;
        step_reg  <= step_next;
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        probe_next = probe_reg;
        ci_next    = ci_reg;
        cf_next    = cf_reg;
        up_next    = up_reg;
        dmin_next  = dmin_reg;
        dnode_next = dnode_reg;
        dir_next   = dir_reg;
        lmax_next  = lmax_reg;
        l_next     = l_reg;
        t_next     = t_reg;
        first_next = first_reg;
        last_next  = last_reg;
        s_next     = s_reg;
        step_next  = step_reg;

        lmax_dbl  = lmax_reg <<< 1;
        l_new     = (plen > dmin_reg) ? (l_reg + t_reg) : l_reg;
        t_half    = t_reg >>> 1;
        l_off     = '0;
        span      = last_reg - first_reg;
        step_half = (step_reg + ONE) >>> 1;
        s_new     = ((probe_reg < last_reg) && (plen > dnode_reg)) ? (s_reg + step_reg)
                                                                   : s_reg;
        dir_up    = up_reg > plen;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    i_next     = POS_W'(start_idx);
                    probe_next = POS_W'(start_idx);
                    state_next = ST_CI;
                end
            end
            ST_CI: begin
                ci_next    = rdata;
                probe_next = i_reg + ONE;
                state_next = ST_UP;
            end
            ST_UP: begin
                up_next    = plen;
                probe_next = i_reg - ONE;
                state_next = ST_DN;
            end
            ST_DN: begin
                dir_next   = dir_up;
                dmin_next  = dir_up ? plen : up_reg;
                lmax_next  = TWO;
                probe_next = dir_up ? (i_reg + TWO) : (i_reg - TWO);
                state_next = ST_GROW;
            end
            ST_GROW: begin
                if (plen > dmin_reg) begin
                    lmax_next  = lmax_dbl;
                    probe_next = dir_reg ? (i_reg + lmax_dbl) : (i_reg - lmax_dbl);
                end else begin
                    l_next     = '0;
                    t_next     = lmax_reg >>> 1;
                    l_off      = lmax_reg >>> 1;
                    probe_next = dir_reg ? (i_reg + l_off) : (i_reg - l_off);
                    state_next = ST_BIN;
                end
            end
            ST_BIN: begin
                l_next = l_new;
                if (t_half != '0) begin
                    t_next     = t_half;
                    l_off      = l_new + t_half;
                    probe_next = dir_reg ? (i_reg + l_off) : (i_reg - l_off);
                end else begin
                    l_off      = dir_reg ? (i_reg + l_new) : (i_reg - l_new);
                    first_next = dir_reg ? i_reg : l_off;
                    last_next  = dir_reg ? l_off : i_reg;
                    probe_next = dir_reg ? i_reg : l_off;
                    state_next = ST_CF;
                end
            end
            ST_CF: begin
                cf_next    = rdata;
                probe_next = last_reg;
                state_next = ST_DNODE;
            end
            ST_DNODE: begin
                dnode_next = plen;
                s_next     = '0;
                if (span > ONE) begin
                    l_off      = (span + ONE) >>> 1;
                    step_next  = l_off;
                    probe_next = first_reg + l_off;
                    state_next = ST_SPLIT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SPLIT: begin
                s_next = s_new;
                if (step_reg > ONE) begin
                    step_next  = step_half;
                    probe_next = first_reg + s_new + step_half;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        oob_next = (probe_next < 0) || (probe_next >= n_pos);
    end

    // Read address follows the next probe so the registered read data lines up with probe_reg
    assign raddr = ADDR_W'(probe_next);

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);

    assign split = first_reg + s_reg;

    always_comb begin
        res.range_first   = IDX_W'(first_reg);
        res.range_last    = IDX_W'(last_reg);
        res.split_pos     = IDX_W'(split);
        res.left_is_leaf  = (s_reg == '0);
        res.right_is_leaf = ((split + ONE) == last_reg);
        res.left_child    = res.left_is_leaf ? CHILD_W'(n_pos - ONE + split)
                                             : CHILD_W'(split);
        res.right_child   = res.right_is_leaf ? CHILD_W'(n_pos + split)
                                              : CHILD_W'(split + ONE);
    end

endmodule

FILE: design/lbvh_internal_node_builder.sv
// Radix-tree internal node builder over sorted Morton codes. Load the sorted
// codes first with write transfers (s_tuser = 0, one code per transfer, one
// transfer per cycle while idle), set leaf_count through cfg_we/cfg_wdata
// while the block is idle, then send build transfers (s_tuser = 1) naming
// internal nodes 0 .. leaf_count-2. Each build gives one result transfer
// holding the node's leaf range, its split and both child indices in the
// combined node array (internal nodes first, leaves from leaf_count-1), plus
// the two leaf flags; a build of a node number beyond the tree gives nothing.
// A build reads only codes that were written before; stale or unwritten
// positions give meaningless results. One shared prefix-length unit, fed by
// the code memory read port, does all the work: every step is one memory
// read and one compare, one step per cycle. A build runs through three fixed
// reads (the node's own code and both neighbours), the exponential range
// search and its binary refinement, one read each of the range's first and
// last codes, the split search and the hand-over of the result. s_tready is
// low for the whole of a build; a finished result sits in the output register
// and does not hold back the next transfer.
module lbvh_internal_node_builder #(
    parameter int MAX_LEAVES = lbvh_pkg::MAX_LEAVES_DEF,
    parameter int CODE_BITS  = lbvh_pkg::CODE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Leaf count register
    input  logic                               cfg_we,
    input  logic [lbvh_pkg::LC_W-1:0]          cfg_wdata,

    // Commands
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lbvh_pkg::S_TDATA_W-1:0]     s_tdata,   // index[9:0], code[39:10]
    input  logic                               s_tuser,   // command

    // Node results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lbvh_pkg::M_TDATA_W-1:0]     m_tdata,   // range_first[9:0],
                                                          // range_last[19:10],
                                                          // split_pos[29:20],
                                                          // left_child[40:30],
                                                          // right_child[51:41], zeros
    output logic [lbvh_pkg::M_TUSER_W-1:0]     m_tuser    // left_is_leaf[0],
                                                          // right_is_leaf[1]
);
    import lbvh_pkg::*;

    localparam int ADDR_W = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;

    logic [LC_W-1:0]      leaf_count_reg;
    logic [LC_W-1:0]      n_eff;

    logic                 s_xfer;
    logic [IDX_W-1:0]     s_index;
    logic [CODE_IN_W-1:0] s_code;
    logic                 wr_en;
    logic                 build_start;

    logic [ADDR_W-1:0]    raddr;
    logic [CODE_BITS-1:0] rdata;
    logic                 seq_idle;
    logic                 res_valid;
    logic                 res_take;
    node_t                res;

    logic                 m_valid_reg;
    node_t                m_node_reg;

    // Hold the leaf count; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leaf_count_reg <= LEAF_COUNT_RESET;
        end else if (cfg_we) begin
            leaf_count_reg <= cfg_wdata;
        end
    end

    // Clamp the leaf count to the tree sizes the store can hold
    always_comb begin
        if (leaf_count_reg < LC_W'(2)) begin
            n_eff = LC_W'(2);
        end else if (leaf_count_reg > MAX_LEAVES) begin
            n_eff = LC_W'(MAX_LEAVES);
        end else begin
            n_eff = leaf_count_reg;
        end
    end

    assign s_index  = s_tdata[IDX_W-1:0];
    assign s_code   = s_tdata[IDX_W +: CODE_IN_W];
    assign s_tready = seq_idle;
    assign s_xfer   = s_tvalid && s_tready;

    // Drop writes past the end of the store and builds past the last internal node
    assign wr_en       = s_xfer && (s_tuser == CMD_WRITE) && (s_index < MAX_LEAVES);
    assign build_start = s_xfer && (s_tuser == CMD_BUILD)
                         && ({1'b0, s_index} < (n_eff - LC_W'(1)));

    lbvh_ram #(
        .WIDTH(CODE_BITS),
        .DEPTH(MAX_LEAVES)
    ) u_code_ram (
        .clk  (aclk),
        .we   (wr_en),
        .waddr(ADDR_W'(s_index)),
        .wdata(CODE_BITS'(s_code)),
        .raddr(raddr),
        .rdata(rdata)
    );

    lbvh_seq #(
        .MAX_LEAVES(MAX_LEAVES),
        .CODE_BITS (CODE_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .n_eff    (n_eff),
        .start    (build_start),
        .start_idx(s_index),
        .rdata    (rdata),
        .raddr    (raddr),
        .idle     (seq_idle),
        .res_valid(res_valid),
        .res_take (res_take),
        .res      (res)
    );

    // Advance the result into the output register once it is free
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_take) begin
            m_node_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_node_reg.right_child, m_node_reg.left_child,
                                  m_node_reg.split_pos, m_node_reg.range_last,
                                  m_node_reg.range_first});
    assign m_tuser  = {m_node_reg.right_is_leaf, m_node_reg.left_is_leaf};

endmodule
